[src/itb_pkg.sv]
// shared types and constants for the interval timer bank
// no dependencies
package itb_pkg;

    localparam int NUM_TIMERS = 32;
    localparam int TICK_BITS  = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_TICK    = 4'd1,
        OP_POLL    = 4'd2,
        OP_ENABLE  = 4'd3,
        OP_DISABLE = 4'd4,
        OP_SETIVL  = 4'd5,
        OP_ADVANCE = 4'd6,
        OP_RESTART = 4'd7,
        OP_QUERY   = 4'd8
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;

    // one timer entry, handed cell to cell around the ring
    typedef struct packed {
        tick_t start;
        tick_t period;
        logic  en;
        logic  intr;
        logic  restart;
    } entry_t;

    // per-cycle control given to each cell
    typedef struct packed {
        logic  shift;
        logic  load;
        tick_t now;
        entry_t load_word;
    } cell_ctl_t;

    function automatic logic expired(input entry_t e, input tick_t now);
        tick_t d;
        d = now - e.start + tick_t'(1);
        return e.period < d;
    endfunction

endpackage

[src/itb_cell.sv]
// one timer cell of the rotating ring
// depends on itb_pkg
module itb_cell
    import itb_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    prev,
    output entry_t    cur
);

    entry_t entry_reg;

    // rotate or take a new word; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= ctl.load_word;
        end
        else if (ctl.shift)
        begin
            entry_reg <= prev;
        end
    end

    assign cur = entry_reg;

endmodule

[src/interval_timer_bank_top.sv]
// top level of the interval timer bank: ring of cells plus sequencer
// depends on itb_pkg, itb_cell
//
// Usage: drive a command word on the input ports and raise start while busy
// is low; the word is taken at that edge. Each result word appears for one
// cycle marked by out_valid; last marks the final word of a command.
// The timers sit in a ring of NUM_TIMERS cells that turns by one position a
// cycle while a command is served. Every command rotates the ring once
// around, and the next command is accepted only after that. Cell 0 is the
// head, where the addressed or scanned slot is read and rewritten.
// A scan emits one word per fired timer in index order; each fired word is
// held back until the next one is found or the scan ends, so that last can
// be set. A scan with nothing fired emits no word. Other commands up to
// OP_QUERY emit their single word at the end of the rotation; unknown codes
// emit no word.
// Reset clears the tick counter, the slot count and the sequencer; timer
// contents are undefined until added. The receiver cannot stall.
module interval_timer_bank_top
    import itb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic [5:0]  timer_index,
    input  logic [31:0] interval_ticks,
    input  logic        irq_class,
    input  logic        auto_restart,
    input  logic        start_enabled,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [5:0]  slot,
    output logic        fired,
    output logic        expired_now,
    output logic [31:0] remaining_ticks,
    output logic        last
);

    localparam int POS_W = $clog2(NUM_TIMERS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    tick_t  count_reg, count_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]  op_reg;
    logic [5:0]  idx_reg;
    tick_t       ivl_reg;
    logic        intr_reg, ar_reg, en_reg;

    // output register
    logic        ov_next;
    logic [1:0]  st_next;
    logic [5:0]  sl_reg, sl_next;
    logic        fi_next;
    logic        ex_reg, ex_next;
    tick_t       rm_reg, rm_next;
    logic        la_next;

    cell_ctl_t ctl [NUM_TIMERS];
    entry_t    cur [NUM_TIMERS];
    entry_t    head_new;
    logic      head_wr;

    // ring of cells; cell i takes from cell i+1, the tail from the rewrite path
    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            itb_cell u_cell (
                .clk  (clk),
                .ctl  (ctl[g]),
                .prev (cur[(g + 1) % NUM_TIMERS]),
                .cur  (cur[g])
            );
        end
    endgenerate

    logic running, head_used, last_step, hit, scan_op, addr_op, idx_ok;
    assign running   = (state_reg == S_RUN);
    assign head_used = ({{(CNT_W-POS_W){1'b0}}, pos_reg} < used_reg);
    assign last_step = (pos_reg == POS_W'(NUM_TIMERS - 1));
    assign scan_op   = (op_reg == OP_TICK) || (op_reg == OP_POLL);
    assign addr_op   = (op_reg >= OP_ENABLE) && (op_reg <= OP_QUERY);
    assign idx_ok    = ({1'b0, idx_reg} < 7'(used_reg));
    assign hit       = ({{(IDX_W-POS_W){1'b0}}, pos_reg} == idx_reg);

    // head rewrite: the head cell's entry is modified as it wraps to the tail
    always_comb
    begin
        head_new = cur[0];
        head_wr  = 1'b0;
        if (running && scan_op && head_used)
        begin
            if ((cur[0].intr == (op_reg == OP_TICK)) && cur[0].en
                && expired(cur[0], count_reg) && cur[0].restart)
            begin
                head_new.start = count_reg;
            end
        end
        else if (running && addr_op && idx_ok && hit)
        begin
            case (op_reg)
                OP_ENABLE:
                begin
                    head_new.en    = 1'b1;
                    head_new.start = count_reg;
                end
                OP_DISABLE: head_new.en = 1'b0;
                OP_SETIVL:  head_new.period = ivl_reg;
                OP_ADVANCE: head_new.start = cur[0].start + cur[0].period;
                OP_RESTART: head_new.start = count_reg;
                default:    head_new = cur[0];
            endcase
        end
        else if (running && op_reg == OP_ADD && used_reg < CNT_W'(NUM_TIMERS)
                 && {{(CNT_W-POS_W){1'b0}}, pos_reg} == used_reg)
        begin
            head_new.start   = count_reg;
            head_new.period  = ivl_reg;
            head_new.en      = en_reg;
            head_new.intr    = intr_reg;
            head_new.restart = ar_reg;
        end
        head_wr = running;
    end

    // cell controls: all rotate; the tail takes the rewritten head
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            ctl[i].shift     = running;
            ctl[i].load      = (i == NUM_TIMERS - 1) && head_wr;
            ctl[i].now       = count_reg;
            ctl[i].load_word = head_new;
        end
    end

    // sequencer and result generation
    always_comb
    begin
        logic f;
        state_next = state_reg;
        count_next = count_reg;
        used_next  = used_reg;
        pos_next   = pos_reg;
        ov_next = 1'b0;
        st_next = ST_OK;
        sl_next = '0;
        fi_next = 1'b0;
        ex_next = 1'b0;
        rm_next = '0;
        la_next = 1'b0;
        f = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    pos_next   = '0;
                    if (operation == OP_TICK)
                    begin
                        count_next = count_reg + tick_t'(1);
                    end
                end
            end
            S_RUN:
            begin
                pos_next = pos_reg + POS_W'(1);
                if (scan_op && head_used)
                begin
                    f = (cur[0].intr == (op_reg == OP_TICK)) && cur[0].en
                        && expired(cur[0], count_reg);
                end
                if (addr_op && idx_ok && hit && op_reg == OP_QUERY)
                begin
                    ex_next = expired(cur[0], count_reg);
                    rm_next = cur[0].start + cur[0].period - count_reg;
                end
                if (last_step)
                begin
                    state_next = S_IDLE;
                end
                // scan word from the head; last is set when the held word is flushed
                if (f)
                begin
                    ov_next = 1'b1;
                    fi_next = 1'b1;
                    sl_next = IDX_W'(pos_reg);
                end
                else if (last_step && !scan_op && op_reg <= OP_QUERY)
                begin
                    ov_next = 1'b1;
                    la_next = 1'b1;
                    if (op_reg == OP_ADD)
                    begin
                        if (used_reg >= CNT_W'(NUM_TIMERS))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            sl_next   = IDX_W'(used_reg);
                            used_next = used_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        sl_next = idx_reg;
                        if (!idx_ok)
                        begin
                            st_next = ST_IDX;
                            ex_next = 1'b0;
                            rm_next = '0;
                        end
                        else if (op_reg == OP_QUERY && !hit)
                        begin
                            ex_next = ex_reg;
                            rm_next = rm_reg;
                        end
                    end
                end
                if (!(last_step && !scan_op) && !f && op_reg == OP_QUERY)
                begin
                    if (addr_op && idx_ok && hit)
                    begin
                        // hold captured query values in the output register
                    end
                    else
                    begin
                        ex_next = ex_reg;
                        rm_next = rm_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // scan words are delayed one stage so last can be set on the final one
    logic        sv_reg;
    logic [5:0]  ssl_reg;
    logic        scan_end;
    logic        scan_flush;
    assign scan_end   = running && last_step && scan_op;
    // pending scan word leaves when another follows, the scan ends, or after it
    assign scan_flush = sv_reg && ((ov_next && fi_next) || scan_end || !running);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            used_reg  <= '0;
            pos_reg   <= '0;
            sv_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            pos_reg   <= pos_next;
            if (scan_flush)
            begin
                sv_reg <= ov_next && fi_next;
            end
            else if (ov_next && fi_next && !scan_end)
            begin
                sv_reg <= 1'b1;
            end
            out_valid <= (ov_next && !fi_next) || scan_flush
                         || (scan_end && ov_next && fi_next);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= operation;
            idx_reg  <= timer_index;
            ivl_reg  <= interval_ticks;
            intr_reg <= irq_class;
            ar_reg   <= auto_restart;
            en_reg   <= start_enabled;
        end
        if (ov_next && fi_next)
        begin
            ssl_reg <= sl_next;
        end
        ex_reg <= ex_next;
        rm_reg <= rm_next;
        // choose what shows on the ports next cycle
        if (scan_flush)
        begin
            sl_reg <= ssl_reg;
            status <= ST_OK;
            fired  <= 1'b1;
            expired_now     <= 1'b0;
            remaining_ticks <= '0;
            last   <= !running || (scan_end && !(ov_next && fi_next));
        end
        else if (scan_end && ov_next && fi_next)
        begin
            sl_reg <= sl_next;
            status <= ST_OK;
            fired  <= 1'b1;
            expired_now     <= 1'b0;
            remaining_ticks <= '0;
            last   <= 1'b1;
        end
        else
        begin
            sl_reg <= sl_next;
            status <= st_next;
            fired  <= 1'b0;
            expired_now     <= ex_next;
            remaining_ticks <= rm_next;
            last   <= la_next;
        end
    end

    assign slot = sl_reg;
    assign busy = (state_reg != S_IDLE);

endmodule

[src/itb_checker.sv]
// port-level checks for the interval timer bank
// depends on itb_pkg; bound to interval_timer_bank_top
module itb_checker
    import itb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       out_valid,
    input logic [1:0] status,
    input logic       fired,
    input logic       expired_now,
    input logic       last
);

    // an accepted command makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised");

    // fired words never carry query data
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> !expired_now && status == ST_OK)
        else $error("fired word malformed");

    // non-scan words are always final
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> last)
        else $error("single word without last");

    // no word while the block stays idle after the last word has drained
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) && !$past(busy, 2) |-> !out_valid)
        else $error("word while idle");

endmodule

bind interval_timer_bank_top itb_checker u_itb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .out_valid   (out_valid),
    .status      (status),
    .fired       (fired),
    .expired_now (expired_now),
    .last        (last)
);

[tb/testbench.sv]
// self-checking testbench for interval_timer_bank_top: queue-fed driver, monitor
// and a behavioral timer table predicting every result word; depends on itb_pkg
`timescale 1ns / 1ps
module testbench;
    import itb_pkg::*;

    typedef struct {
        logic [3:0]  op;
        logic [5:0]  idx;
        logic [31:0] ivl;
        logic        intr;
        logic        arst;
        logic        en;
    } cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic        fired;
        logic        expd;
        logic [31:0] rem;
        logic        last;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  operation = '0;
    logic [5:0]  timer_index = '0;
    logic [31:0] interval_ticks = '0;
    logic        irq_class = 1'b0;
    logic        auto_restart = 1'b0;
    logic        start_enabled = 1'b0;
    logic        out_valid;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        fired;
    logic        expired_now;
    logic [31:0] remaining_ticks;
    logic        last;

    cmd_t  pending_cmds[$];
    word_t expected_words[$];
    int    errors = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    gen_used = 0;

    // shadow timer table
    tick_t       shadow_count = '0;
    int          shadow_used = 0;
    tick_t       shadow_start[NUM_TIMERS];
    tick_t       shadow_period[NUM_TIMERS];
    logic        shadow_en[NUM_TIMERS];
    logic        shadow_intr[NUM_TIMERS];
    logic        shadow_restart[NUM_TIMERS];

    interval_timer_bank_top u_dut (.*);

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic timer_due(input int i);
        tick_t d;
        d = shadow_count - shadow_start[i] + tick_t'(1);
        return shadow_period[i] < d;
    endfunction

    function automatic void push_word(input logic [1:0] st, input int s, input logic f,
                                      input logic e, input logic [31:0] r, input logic l);
        word_t w;
        w.status = st;
        w.slot = 6'(s);
        w.fired = f;
        w.expd = e;
        w.rem = r;
        w.last = l;
        expected_words.push_back(w);
    endfunction

    // scan one timer class, one word per fired timer
    function automatic void scan_timers(input logic cls);
        word_t w;
        int n;
        n = 0;
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_intr[i] == cls && shadow_en[i] && timer_due(i)) begin
                if (shadow_restart[i])
                    shadow_start[i] = shadow_count;
                push_word(ST_OK, i, 1'b1, 1'b0, '0, 1'b0);
                n++;
            end
        end
        if (n > 0) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void predict_timer_words(input cmd_t c);
        int i;
        i = c.idx;
        if (c.op == OP_ADD) begin
            if (shadow_used >= NUM_TIMERS) begin
                push_word(ST_FULL, 0, 1'b0, 1'b0, '0, 1'b1);
            end
            else begin
                shadow_en[shadow_used] = c.en;
                shadow_period[shadow_used] = c.ivl;
                shadow_start[shadow_used] = shadow_count;
                shadow_intr[shadow_used] = c.intr;
                shadow_restart[shadow_used] = c.arst;
                push_word(ST_OK, shadow_used, 1'b0, 1'b0, '0, 1'b1);
                shadow_used++;
            end
        end
        else if (c.op == OP_TICK) begin
            shadow_count = shadow_count + tick_t'(1);
            scan_timers(1'b1);
        end
        else if (c.op == OP_POLL) begin
            scan_timers(1'b0);
        end
        else if (c.op > OP_QUERY) begin
            // unknown codes produce nothing
        end
        else if (i >= shadow_used) begin
            push_word(ST_IDX, i, 1'b0, 1'b0, '0, 1'b1);
        end
        else begin
            case (c.op)
                OP_ENABLE:
                begin
                    shadow_en[i] = 1'b1;
                    shadow_start[i] = shadow_count;
                end
                OP_DISABLE:  shadow_en[i] = 1'b0;
                OP_SETIVL:   shadow_period[i] = c.ivl;
                OP_ADVANCE:  shadow_start[i] = shadow_start[i] + shadow_period[i];
                OP_RESTART:  shadow_start[i] = shadow_count;
                default:     ;
            endcase
            if (c.op == OP_QUERY)
                push_word(ST_OK, i, 1'b0, timer_due(i),
                          shadow_start[i] + shadow_period[i] - shadow_count, 1'b1);
            else
                push_word(ST_OK, i, 1'b0, 1'b0, '0, 1'b1);
        end
    endfunction

    // driver: bursts of commands with random gaps
    always @(posedge clk) begin
        cmd_t c;
        logic taken;
        if (rst_n) begin
            taken = start && !busy;
            if (taken) begin
                c.op = operation;
                c.idx = timer_index;
                c.ivl = interval_ticks;
                c.intr = irq_class;
                c.arst = auto_restart;
                c.en = start_enabled;
                predict_timer_words(c);
            end
            if (!start || taken) begin
                if (gap_left > 0 || pending_cmds.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else begin
                    c = pending_cmds.pop_front();
                    operation <= c.op;
                    timer_index <= c.idx;
                    interval_ticks <= c.ivl;
                    irq_class <= c.intr;
                    auto_restart <= c.arst;
                    start_enabled <= c.en;
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end
            end
        end
    end

    // monitor: each result word against the oldest expectation
    always @(posedge clk) begin
        word_t w;
        if (rst_n && out_valid) begin
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word slot %0d status %0d", slot, status));
            end
            else begin
                w = expected_words.pop_front();
                if (status !== w.status || slot !== w.slot || fired !== w.fired ||
                    expired_now !== w.expd || remaining_ticks !== w.rem || last !== w.last)
                    report($sformatf(
                        "got st%0d sl%0d f%0d e%0d r%h l%0d, want st%0d sl%0d f%0d e%0d r%h l%0d",
                        status, slot, fired, expired_now, remaining_ticks, last,
                        w.status, w.slot, w.fired, w.expd, w.rem, w.last));
            end
        end
    end

    function automatic void queue_cmd(input logic [3:0] op, input int idx,
                                      input logic [31:0] ivl, input int intr,
                                      input int arst, input int en);
        cmd_t c;
        c.op = op;
        c.idx = 6'(idx);
        c.ivl = ivl;
        c.intr = 1'(intr);
        c.arst = 1'(arst);
        c.en = 1'(en);
        pending_cmds.push_back(c);
        if (op == OP_ADD && gen_used < NUM_TIMERS)
            gen_used++;
    endfunction

    // random interval: mostly short so timers expire often
    function automatic logic [31:0] rand_interval();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 4);
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    // stimulus
    initial begin
        int pick;
        int idx;
        logic [3:0] op;
        // directed: empty table, unknown codes, field extremes
        queue_cmd(OP_QUERY, 0, '0, 0, 0, 0);
        queue_cmd(OP_ENABLE, 63, '0, 0, 0, 0);
        queue_cmd(OP_TICK, 0, '0, 0, 0, 0);
        queue_cmd(OP_POLL, 0, '0, 0, 0, 0);
        queue_cmd(4'd9, 0, '0, 0, 0, 0);
        queue_cmd(4'd15, 63, 32'hFFFF_FFFF, 1, 1, 1);
        queue_cmd(OP_ADD, 63, 32'd0, 1, 1, 1);
        queue_cmd(OP_ADD, 0, 32'hFFFF_FFFF, 1, 0, 1);
        queue_cmd(OP_ADD, 0, 32'd1, 0, 0, 1);
        queue_cmd(OP_ADD, 0, 32'd2, 0, 1, 0);
        queue_cmd(OP_TICK, 0, '0, 0, 0, 0);
        queue_cmd(OP_TICK, 0, '0, 0, 0, 0);
        queue_cmd(OP_POLL, 0, '0, 0, 0, 0);
        queue_cmd(OP_QUERY, 1, '0, 0, 0, 0);
        queue_cmd(OP_QUERY, 2, '0, 0, 0, 0);
        queue_cmd(OP_ENABLE, 3, '0, 0, 0, 0);
        queue_cmd(OP_SETIVL, 2, 32'hAAAA_5555, 0, 0, 0);
        queue_cmd(OP_ADVANCE, 2, '0, 0, 0, 0);
        queue_cmd(OP_RESTART, 0, '0, 0, 0, 0);
        queue_cmd(OP_DISABLE, 0, '0, 0, 0, 0);
        queue_cmd(OP_QUERY, 4, '0, 0, 0, 0);
        queue_cmd(OP_POLL, 0, '0, 0, 0, 0);
        // random: fill the table gradually, then a few past full
        for (int n = 0; n < 400; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                op = OP_ADD;
            else if (pick < 40)
                op = OP_TICK;
            else if (pick < 55)
                op = OP_POLL;
            else if (pick < 98)
                op = 4'($urandom_range(OP_ENABLE, OP_QUERY));
            else
                op = 4'($urandom_range(9, 15));
            if (gen_used > 0 && $urandom_range(0, 9) < 8)
                idx = $urandom_range(0, gen_used - 1);
            else
                idx = $urandom_range(0, 63);
            queue_cmd(op, idx, rand_interval(), $urandom_range(0, 1), $urandom_range(0, 1),
                      ($urandom_range(0, 3) != 0) ? 1 : 0);
            if (op <= OP_QUERY)
                n++;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
